// File: src/otb_pkg.sv
// Shared definitions for the one-shot timer bank: operation codes, the
// default bank size and the controller/datapath interface structs.
// Depends on nothing; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package otb_pkg;

	localparam int CHANNELS_DEFAULT = 16;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_SCAN   = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // item accepted this cycle
		logic scan_step;  // read the next channel's timer entry
		logic report;     // capture the result registers
	} otb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;  // the entry being read is the last channel
	} otb_status_t;

endpackage

`default_nettype wire

// File: src/otb_ctrl.sv
// Controller of the one-shot timer bank: accepts items, sequences the
// channel scan and times the result strobe. Depends on otb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otb_ctrl
	import otb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [1:0]  operation,
	input  wire otb_status_t status,
	output otb_cmd_t         cmd,
	output logic             busy,
	output logic             done
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_REPORT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.scan_step = 1'b0;
		cmd.report    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = (operation == OP_SCAN) ? S_SCAN : S_REPORT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			// The last entry is compared while the controller waits here.
			S_DRAIN: begin
				state_d = S_REPORT;
			end
			S_REPORT: begin
				cmd.report = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.report;
		end
	end

endmodule

`default_nettype wire

// File: src/otb_datapath.sv
// Datapath of the one-shot timer bank: millisecond counter, channel flags,
// the timer entry memory, the scan compare stage and the result registers.
// Depends on otb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module otb_datapath
	import otb_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire otb_cmd_t    cmd,
	output otb_status_t      status,
	input  wire logic [1:0]  operation,
	input  wire logic [3:0]  channel,
	input  wire logic [31:0] duration_ms,
	output logic             running,
	output logic             expired,
	output logic [15:0]      running_mask,
	output logic [15:0]      expired_mask
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [6:0] CH_COUNT = 7'(CHANNELS);
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	logic [31:0]         now_q;
	logic [CHANNELS-1:0] armed_q;
	logic [CHANNELS-1:0] run_flag_q;
	logic [CHANNELS-1:0] exp_flag_q;

	// Each entry holds the start time in the upper half, the length below.
	logic [63:0]         entry_mem [CHANNELS];

	logic [CH_W-1:0]     scan_idx_q;
	logic [CH_W-1:0]     idx_s1;
	logic                valid_s1;
	logic [63:0]         entry_s1;
	logic [31:0]         elapsed_s1;
	logic                hit_s1;

	logic [CH_W-1:0]     chan_q;
	logic                in_bank_q;
	logic                in_bank;
	logic [CH_W-1:0]     ch_idx;
	logic                do_start;
	logic                do_cancel;

	logic                running_q;
	logic                expired_q;
	logic [15:0]         running_mask_q;
	logic [15:0]         expired_mask_q;

	assign in_bank   = ({3'b000, channel} < CH_COUNT);
	assign ch_idx    = CH_W'(channel);
	assign do_start  = cmd.load && (operation == OP_START) && in_bank && !armed_q[ch_idx];
	assign do_cancel = cmd.load && (operation == OP_CANCEL) && in_bank;

	assign status.scan_last = (scan_idx_q == LAST_CH);

	assign elapsed_s1 = now_q - entry_s1[63:32];
	assign hit_s1     = valid_s1 && armed_q[idx_s1] && (elapsed_s1 >= entry_s1[31:0]);

	always_ff @(posedge clk) begin
		if (do_start) begin
			entry_mem[ch_idx] <= {now_q, duration_ms};
		end
		if (cmd.scan_step) begin
			entry_s1 <= entry_mem[scan_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q      <= '0;
			armed_q    <= '0;
			run_flag_q <= '0;
			exp_flag_q <= '0;
			scan_idx_q <= '0;
			idx_s1     <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cmd.load && (operation == OP_TICK)) begin
				now_q <= now_q + 32'd1;
			end
			if (do_start) begin
				armed_q[ch_idx]    <= 1'b1;
				run_flag_q[ch_idx] <= 1'b1;
				exp_flag_q[ch_idx] <= 1'b0;
			end
			if (do_cancel) begin
				armed_q[ch_idx]    <= 1'b0;
				run_flag_q[ch_idx] <= 1'b0;
				exp_flag_q[ch_idx] <= 1'b0;
			end
			if (hit_s1) begin
				run_flag_q[idx_s1] <= 1'b0;
				exp_flag_q[idx_s1] <= 1'b1;
			end
			valid_s1 <= cmd.scan_step;
			if (cmd.scan_step) begin
				idx_s1     <= scan_idx_q;
				// The index wraps to zero after the last channel, ready for the next scan.
				scan_idx_q <= status.scan_last ? '0 : scan_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			chan_q    <= ch_idx;
			in_bank_q <= in_bank;
		end
		if (cmd.report) begin
			running_q      <= in_bank_q && run_flag_q[chan_q];
			expired_q      <= in_bank_q && exp_flag_q[chan_q];
			running_mask_q <= 16'(run_flag_q);
			expired_mask_q <= 16'(exp_flag_q);
		end
	end

	assign running      = running_q;
	assign expired      = expired_q;
	assign running_mask = running_mask_q;
	assign expired_mask = expired_mask_q;

endmodule

`default_nettype wire

// File: src/one_shot_timer_bank.sv
// Top level of the one-shot timer bank: joins the controller and the
// datapath. Depends on otb_pkg, otb_ctrl and otb_datapath.
//
// Usage:
//   An item (operation, channel, duration_ms) is taken at a rising edge
//   where start is high and busy is low. Operations: start a channel,
//   cancel a channel, advance the millisecond counter, scan all channels.
//   Each item gives one result (running, expired, running_mask,
//   expired_mask), shown for exactly one cycle while done is high.
//   Start, cancel and tick take effect at the accepting edge; such an item
//   then passes through the report state, whose registered strobe is done.
//   A scan reads one timer entry per cycle from the entry memory and
//   compares it in the following cycle; after the last channel it passes
//   through a drain state, for the last compare, and the report state.
//   The receiver cannot stall: each result is presented once, and the
//   block is idle again in the cycle done is high.
//   Reset clears the counter and all channel flags at once; the timer
//   entries need no clearing because a hit counts only on an armed channel.
`timescale 1ns / 1ps
`default_nettype none

module one_shot_timer_bank
	import otb_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [3:0]  channel,
	input  wire logic [31:0] duration_ms,
	output logic             done,
	output logic             running,
	output logic             expired,
	output logic [15:0]      running_mask,
	output logic [15:0]      expired_mask
);

	otb_cmd_t    cmd;
	otb_status_t status;

	otb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	otb_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.operation    (operation),
		.channel      (channel),
		.duration_ms  (duration_ms),
		.running      (running),
		.expired      (expired),
		.running_mask (running_mask),
		.expired_mask (expired_mask)
	);

endmodule

`default_nettype wire

// File: src/otb_checker.sv
// Port-level checks for the one-shot timer bank, bound to its top level.
// Depends on one_shot_timer_bank's ports only.
`timescale 1ns / 1ps
`default_nettype none

module otb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        running,
	input wire logic        expired,
	input wire logic [15:0] running_mask,
	input wire logic [15:0] expired_mask
);

	// An accepted item keeps the block busy until its result is out.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// The result strobe lasts one cycle and comes as busy falls.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// A channel is never counting and expired at the same time.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!(running && expired) && ((running_mask & expired_mask) == 16'h0000)))
		else $error("running and expired both set");

endmodule

bind one_shot_timer_bank otb_checker u_otb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.running      (running),
	.expired      (expired),
	.running_mask (running_mask),
	.expired_mask (expired_mask)
);

`default_nettype wire

// File: test/timer_bank_checker.sv
// Checker for the one-shot timer bank: keeps its own copy of the channel state,
// predicts the status of every accepted item and compares each result on done.
// Depends on otb_pkg for the operation codes.
`timescale 1ns / 1ps

module timer_bank_checker
	import otb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  operation,
	input  wire logic [3:0]  channel,
	input  wire logic [31:0] duration_ms,
	input  wire logic        done,
	input  wire logic        running,
	input  wire logic        expired,
	input  wire logic [15:0] running_mask,
	input  wire logic [15:0] expired_mask,
	output int               mismatch_count,
	output int               outstanding
);

	localparam int NUM_CH = 16;

	typedef struct packed {
		logic        running;
		logic        expired;
		logic [15:0] running_mask;
		logic [15:0] expired_mask;
	} bank_status_t;

	logic [31:0]       clock_ms;
	logic [31:0]       armed_at [NUM_CH];
	logic [31:0]       timeout_of [NUM_CH];
	logic [NUM_CH-1:0] armed;
	logic [NUM_CH-1:0] counting;
	logic [NUM_CH-1:0] timed_out;
	bank_status_t      pending_status [$];

	// Applies one item to the shadow state and queues the status it reports.
	task automatic predict_status(input logic [1:0] op, input logic [3:0] ch,
			input logic [31:0] dur);
		bank_status_t st;
		logic [31:0]  elapsed;
		int           c;
		case (op)
			OP_START: begin
				if (!armed[ch]) begin
					timeout_of[ch] = dur;
					armed_at[ch]   = clock_ms;
					timed_out[ch]  = 1'b0;
					counting[ch]   = 1'b1;
					armed[ch]      = 1'b1;
				end
			end
			OP_CANCEL: begin
				timed_out[ch] = 1'b0;
				counting[ch]  = 1'b0;
				armed[ch]     = 1'b0;
			end
			OP_TICK: begin
				clock_ms = clock_ms + 32'd1;
			end
			default: begin
				for (c = 0; c < NUM_CH; c++) begin
					elapsed = clock_ms - armed_at[c];
					if (armed[c] && elapsed >= timeout_of[c]) begin
						timed_out[c] = 1'b1;
						counting[c]  = 1'b0;
					end
				end
			end
		endcase
		st.running      = counting[ch];
		st.expired      = timed_out[ch];
		st.running_mask = counting;
		st.expired_mask = timed_out;
		pending_status.push_back(st);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bank_status_t want;
		if (!arst_n) begin
			clock_ms  = '0;
			armed     = '0;
			counting  = '0;
			timed_out = '0;
			for (int c = 0; c < NUM_CH; c++) begin
				armed_at[c]   = '0;
				timeout_of[c] = '0;
			end
			pending_status.delete();
			outstanding = 0;
		end else begin
			// The result of the previous item is checked before the item taken at
			// this same edge is applied.
			if (done) begin
				if (pending_status.size() == 0) begin
					$error("result arrived with no item waiting for it");
					mismatch_count++;
				end else begin
					want = pending_status.pop_front();
					if (running !== want.running) begin
						$error("running: expected %0d, got %0d", want.running, running);
						mismatch_count++;
					end
					if (expired !== want.expired) begin
						$error("expired: expected %0d, got %0d", want.expired, expired);
						mismatch_count++;
					end
					if (running_mask !== want.running_mask) begin
						$error("running_mask: expected %h, got %h",
							want.running_mask, running_mask);
						mismatch_count++;
					end
					if (expired_mask !== want.expired_mask) begin
						$error("expired_mask: expected %h, got %h",
							want.expired_mask, expired_mask);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				predict_status(operation, channel, duration_ms);
			outstanding = pending_status.size();
		end
	end

endmodule

// File: test/tb_top.sv
// Testbench top for the one-shot timer bank: drives directed and random items
// in bursts and gives the verdict. Depends on otb_pkg, one_shot_timer_bank
// and timer_bank_checker.
`timescale 1ns / 1ps

module tb_top;
	import otb_pkg::*;

	localparam int RANDOM_ITEMS = 1300;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [3:0]  channel;
	logic [31:0] duration_ms;
	logic        done;
	logic        running;
	logic        expired;
	logic [15:0] running_mask;
	logic [15:0] expired_mask;
	int          mismatch_count;
	int          outstanding;
	logic        took;
	int          cycle_count = 0;

	always #5 clk = ~clk;

	one_shot_timer_bank i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.channel      (channel),
		.duration_ms  (duration_ms),
		.done         (done),
		.running      (running),
		.expired      (expired),
		.running_mask (running_mask),
		.expired_mask (expired_mask)
	);

	timer_bank_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.channel        (channel),
		.duration_ms    (duration_ms),
		.done           (done),
		.running        (running),
		.expired        (expired),
		.running_mask   (running_mask),
		.expired_mask   (expired_mask),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always @(posedge clk) begin
		took        <= start && !busy;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Presents one item and returns at the falling edge after it is taken.
	task automatic issue(input logic [1:0] op, input logic [3:0] ch,
			input logic [31:0] dur);
		start       <= 1'b1;
		operation   <= op;
		channel     <= ch;
		duration_ms <= dur;
		do @(negedge clk); while (!took);
	endtask

	// Drops start for a number of cycles; the other inputs carry noise meanwhile.
	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			start       <= 1'b0;
			operation   <= 2'($urandom());
			channel     <= 4'($urandom());
			duration_ms <= $urandom();
			repeat (cycles) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Mostly short timeouts so that channels expire within a few ticks.
	function automatic logic [31:0] pick_duration();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return $urandom_range(0, 12);
		else if (sel < 80)
			return $urandom_range(0, 300);
		else if (sel < 94)
			return $urandom();
		else
			return 32'hFFFF_FFFF;
	endfunction

	task automatic issue_random();
		int         sel;
		logic [1:0] op;
		sel = $urandom_range(0, 99);
		if (sel < 32)
			op = OP_START;
		else if (sel < 52)
			op = OP_CANCEL;
		else if (sel < 82)
			op = OP_TICK;
		else
			op = OP_SCAN;
		issue(op, 4'($urandom_range(0, 15)), pick_duration());
	endtask

	initial begin
		int burst_left;
		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = OP_START;
		channel     = '0;
		duration_ms = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: empty scan, zero timeout, start on an armed or expired
		// channel, cancel of an idle channel and the widest timeout.
		issue(OP_SCAN,   4'd0,  32'd0);
		issue(OP_TICK,   4'd5,  32'd0);
		issue(OP_START,  4'd0,  32'd0);
		issue(OP_SCAN,   4'd0,  32'd0);
		issue(OP_START,  4'd0,  32'd5);
		issue(OP_CANCEL, 4'd0,  32'd0);
		issue(OP_START,  4'd15, 32'hFFFF_FFFF);
		issue(OP_START,  4'd1,  32'd2);
		issue(OP_TICK,   4'd1,  32'd0);
		issue(OP_SCAN,   4'd1,  32'd0);
		issue(OP_TICK,   4'd1,  32'd0);
		issue(OP_SCAN,   4'd1,  32'd0);
		issue(OP_START,  4'd1,  32'd0);
		issue(OP_CANCEL, 4'd1,  32'd0);
		issue(OP_CANCEL, 4'd7,  32'd0);
		issue(OP_START,  4'd7,  32'd1);
		issue(OP_SCAN,   4'd7,  32'd0);
		issue(OP_TICK,   4'd15, 32'd0);
		issue(OP_SCAN,   4'd15, 32'd0);
		issue(OP_START,  4'd10, 32'hAAAA_5555);
		issue(OP_CANCEL, 4'd15, 32'd0);
		issue(OP_CANCEL, 4'd7,  32'd0);
		issue(OP_START,  4'd0,  32'd0);
		issue(OP_SCAN,   4'd0,  32'd0);
		wait_drained();

		burst_left = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (burst_left == 0) begin
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 12);
				idle_for($urandom_range(0, 9));
			end
			if (n == RANDOM_ITEMS / 2 || n % 400 == 399)
				wait_drained();
			issue_random();
			burst_left--;
		end

		wait_drained();
		repeat (40) @(negedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
